// ----- sv/biq_pkg.sv -----
// ----------------------------------------------------------------------------
// biq_pkg
// Types, constants and the control program of the biquad filter.
// ----------------------------------------------------------------------------
`default_nettype none

package biq_pkg;

    // Field widths of the sample and coefficient formats.
    localparam int SAMPLE_W  = 16;               // Q1.15
    localparam int COEF_W    = 20;               // Q4.16
    localparam int COEF_FRAC = COEF_W - 4;
    localparam int ACC_W     = 40;               // state accumulators
    localparam int PROD_W    = SAMPLE_W + COEF_W; // full product, fits in ACC_W
    localparam int SUM_W     = ACC_W + 2;        // exact sum of three accumulator terms

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE = 3'd0,
        REG_B0     = 3'd1,
        REG_B1     = 3'd2,
        REG_B2     = 3'd3,
        REG_A1     = 3'd4,
        REG_A2     = 3'd5
    } cfg_index_t;

    // Payloads of the two channels.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       block_end_in;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       block_end_out;
    } out_item_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } coef_set_t;

    // Control word fields.
    typedef enum logic [2:0] {
        COEF_B0 = 3'd0,
        COEF_B1 = 3'd1,
        COEF_B2 = 3'd2,
        COEF_A1 = 3'd3,
        COEF_A2 = 3'd4
    } coef_sel_t;

    typedef enum logic {
        MUL_X = 1'b0,
        MUL_Y = 1'b1
    } mul_src_t;

    typedef enum logic [1:0] {
        ACC_ZERO = 2'd0,
        ACC_SELF = 2'd1,
        ACC_D1   = 2'd2,
        ACC_D2   = 2'd3
    } acc_src_t;

    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_ADD  = 2'd1,
        OP_SUB  = 2'd2
    } acc_op_t;

    typedef enum logic {
        Y_RSAT = 1'b0,
        Y_X    = 1'b1
    } y_src_t;

    typedef enum logic {
        COND_NEVER  = 1'b0,
        COND_BYPASS = 1'b1
    } jump_cond_t;

    localparam int STEP_W = 4;

    // Program entry points.
    localparam logic [STEP_W-1:0] STEP_START  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_BYPASS = 4'd8;

    typedef struct packed {
        coef_sel_t         coef_sel;
        mul_src_t          mul_src;
        logic              mul_en;
        acc_src_t          acc_src;
        acc_op_t           acc_op;
        logic              rnd;
        logic              y_wr;
        y_src_t            y_src;
        logic              d1_wr;
        logic              d2_wr;
        jump_cond_t        cond;
        logic [STEP_W-1:0] target;
        logic              last;
    } ctrl_word_t;

    typedef struct packed {
        ctrl_word_t        ctrl;
        logic              fire;
        logic              done;
        logic              idle;
        logic              run;
        logic [STEP_W-1:0] step;
    } seq_status_t;

    // Control store. The multiplier result is registered, so a product
    // requested in one step is consumed in the next.
    function automatic ctrl_word_t biq_rom(input logic [STEP_W-1:0] step);
        ctrl_word_t w;
        w = ctrl_word_t'('0);
        case (step)
            4'd0: begin   // b0*x; leave for pass-through if filtering is off
                w.coef_sel = COEF_B0; w.mul_src = MUL_X; w.mul_en = 1'b1;
                w.cond = COND_BYPASS; w.target = STEP_BYPASS;
            end
            4'd1: begin   // acc = d1 + b0*x + half LSB; b1*x
                w.acc_src = ACC_D1; w.acc_op = OP_ADD; w.rnd = 1'b1;
                w.coef_sel = COEF_B1; w.mul_src = MUL_X; w.mul_en = 1'b1;
            end
            4'd2: begin   // y = round and saturate; acc = d2 + b1*x
                w.y_wr = 1'b1; w.y_src = Y_RSAT;
                w.acc_src = ACC_D2; w.acc_op = OP_ADD;
            end
            4'd3: begin   // a1*y
                w.coef_sel = COEF_A1; w.mul_src = MUL_Y; w.mul_en = 1'b1;
            end
            4'd4: begin   // acc -= a1*y; b2*x
                w.acc_src = ACC_SELF; w.acc_op = OP_SUB;
                w.coef_sel = COEF_B2; w.mul_src = MUL_X; w.mul_en = 1'b1;
            end
            4'd5: begin   // d1 = sat(acc); acc = b2*x; a2*y
                w.d1_wr = 1'b1;
                w.acc_src = ACC_ZERO; w.acc_op = OP_ADD;
                w.coef_sel = COEF_A2; w.mul_src = MUL_Y; w.mul_en = 1'b1;
            end
            4'd6: begin   // acc -= a2*y
                w.acc_src = ACC_SELF; w.acc_op = OP_SUB;
            end
            4'd7: begin   // d2 = sat(acc); result ready
                w.d2_wr = 1'b1; w.last = 1'b1;
            end
            4'd8: begin   // pass-through: y = x
                w.y_wr = 1'b1; w.y_src = Y_X;
            end
            4'd9: begin
                w.last = 1'b1;
            end
            default: begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- sv/biq_sequencer.sv -----
// ----------------------------------------------------------------------------
// biq_sequencer
// Step counter and control store lookup with a conditional jump.
// ----------------------------------------------------------------------------
`default_nettype none

module biq_sequencer
    import biq_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  start,
    input  wire logic  filter_enable,
    input  wire logic  out_free,
    output seq_status_t status
);

    typedef enum logic [1:0] {
        SEQ_IDLE = 2'b01,
        SEQ_RUN  = 2'b10
    } seq_state_t;

    seq_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    ctrl_word_t        word;
    logic              fire;
    logic              done;
    logic              take_jump;

    always_comb begin
        word      = biq_rom(step_reg);
        // The final step waits until the output register can take the result.
        fire      = (state_reg == SEQ_RUN) && (!word.last || out_free);
        done      = fire && word.last;
        take_jump = (word.cond == COND_BYPASS) && !filter_enable;
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        if (start) begin
            state_next = SEQ_RUN;
            step_next  = STEP_START;
        end else if (fire) begin
            if (word.last) begin
                state_next = SEQ_IDLE;
            end else if (take_jump) begin
                step_next = word.target;
            end else begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEQ_IDLE;
            step_reg  <= STEP_START;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign status.ctrl = word;
    assign status.fire = fire;
    assign status.done = done;
    assign status.idle = (state_reg == SEQ_IDLE);
    assign status.run  = (state_reg == SEQ_RUN);
    assign status.step = step_reg;

endmodule

`default_nettype wire

// ----- sv/biq_datapath.sv -----
// ----------------------------------------------------------------------------
// biq_datapath
// Shared multiplier, accumulator, output rounding and the two delay states.
// ----------------------------------------------------------------------------
`default_nettype none

module biq_datapath
    import biq_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire seq_status_t                seq,
    input  wire logic                       x_load,
    input  wire logic signed [SAMPLE_W-1:0] x_in,
    input  wire coef_set_t                  coefs,
    output logic signed [SAMPLE_W-1:0]      y_out
);

    localparam logic signed [SUM_W-1:0] ROUND = SUM_W'(1) << (COEF_FRAC - 1);
    localparam logic signed [SUM_W-1:0] Y_MAX = SUM_W'((64'sd1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] Y_MIN = -Y_MAX - 1;
    localparam logic signed [ACC_W-1:0] D_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] D_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SAMPLE_W-1:0] y_reg, y_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [SUM_W-1:0]    acc_reg, acc_next;
    logic signed [ACC_W-1:0]    d1_reg, d2_reg;

    logic signed [COEF_W-1:0]   coef_mux;
    logic signed [SAMPLE_W-1:0] mul_op;
    logic signed [SUM_W-1:0]    acc_a;
    logic signed [SUM_W-1:0]    prod_ext;
    logic signed [SUM_W-1:0]    y_shift;
    logic signed [SAMPLE_W-1:0] y_sat;
    logic signed [ACC_W-1:0]    acc_sat;
    logic                       acc_ovf;

    // Multiplier operands.
    always_comb begin
        case (seq.ctrl.coef_sel)
            COEF_B0: coef_mux = coefs.b0;
            COEF_B1: coef_mux = coefs.b1;
            COEF_B2: coef_mux = coefs.b2;
            COEF_A1: coef_mux = coefs.a1;
            COEF_A2: coef_mux = coefs.a2;
            default: coef_mux = coefs.b0;
        endcase
        mul_op    = (seq.ctrl.mul_src == MUL_Y) ? y_reg : x_reg;
        prod_next = coef_mux * mul_op;
    end

    // Accumulator: selected base plus or minus product and rounding half; or hold.
    always_comb begin
        case (seq.ctrl.acc_src)
            ACC_ZERO: acc_a = '0;
            ACC_SELF: acc_a = acc_reg;
            ACC_D1:   acc_a = SUM_W'(d1_reg);
            ACC_D2:   acc_a = SUM_W'(d2_reg);
            default:  acc_a = '0;
        endcase
        // The full product is narrower than the accumulator, so it never clips.
        prod_ext = SUM_W'(prod_reg);
        case (seq.ctrl.acc_op)
            OP_ADD:  acc_next = acc_a + prod_ext + (seq.ctrl.rnd ? ROUND : '0);
            OP_SUB:  acc_next = acc_a - prod_ext + (seq.ctrl.rnd ? ROUND : '0);
            OP_HOLD: acc_next = acc_reg;
            default: acc_next = acc_reg;
        endcase
    end

    // Output sample: floor shift of the rounded sum, then clamp.
    always_comb begin
        y_shift = acc_reg >>> COEF_FRAC;
        if (y_shift > Y_MAX) begin
            y_sat = Y_MAX[SAMPLE_W-1:0];
        end else if (y_shift < Y_MIN) begin
            y_sat = Y_MIN[SAMPLE_W-1:0];
        end else begin
            y_sat = y_shift[SAMPLE_W-1:0];
        end
        y_next = (seq.ctrl.y_src == Y_X) ? x_reg : y_sat;
    end

    // State saturation to the accumulator width.
    always_comb begin
        acc_ovf = (acc_reg[SUM_W-1:ACC_W-1] != {(SUM_W-ACC_W+1){acc_reg[SUM_W-1]}});
        if (acc_ovf) begin
            acc_sat = acc_reg[SUM_W-1] ? D_MIN : D_MAX;
        end else begin
            acc_sat = acc_reg[ACC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (x_load) begin
            x_reg <= x_in;
        end
        if (seq.fire && seq.ctrl.mul_en) begin
            prod_reg <= prod_next;
        end
        if (seq.fire) begin
            acc_reg <= acc_next;
        end
        if (seq.fire && seq.ctrl.y_wr) begin
            y_reg <= y_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_reg <= '0;
            d2_reg <= '0;
        end else begin
            if (seq.fire && seq.ctrl.d1_wr) begin
                d1_reg <= acc_sat;
            end
            if (seq.fire && seq.ctrl.d2_wr) begin
                d2_reg <= acc_sat;
            end
        end
    end

    assign y_out = y_reg;

endmodule

`default_nettype wire

// ----- sv/biquad_iir_filter.sv -----
// ----------------------------------------------------------------------------
// biquad_iir_filter
// Second-order IIR filter, transposed direct form II, on a microcoded datapath.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                               Moves
//   input     s_valid, s_ready, s_data            one sample request
//   output    m_valid, m_ready, m_data            one filtered sample
//   config    cfg_wr_en, cfg_index, cfg_wr_data   one register write
//
// A filtered sample runs steps 0 to 7 of the control program in order; with
// filtering off, a pass-through runs steps 0, 8 and 9. The one multiplier
// runs five products per sample, and the product register feeds the
// accumulator in the following step.
// A new request is taken in the cycle the previous result is handed over.
// Reset clears the delay states and loads the reset coefficients (b0 = 1.0).
// A stalled output holds the sequencer at its last step; nothing is lost.
//
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_iir_filter
    import biq_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data,

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [COEF_W-1:0]     cfg_wr_data
);

    // Configuration registers. The user must make writes only while the filter is idle; the block does not enforce it.
    logic       enable_reg;
    coef_set_t  coef_reg;

    // Block-end flag of the request in flight, and the output register.
    logic        block_end_reg;
    out_item_t   out_reg;
    logic        m_valid_reg;

    seq_status_t seq;
    logic        in_accept;
    logic        out_free;
    logic signed [SAMPLE_W-1:0] y_value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg  <= 1'b0;
            coef_reg.b0 <= COEF_W'(1) << COEF_FRAC;
            coef_reg.b1 <= '0;
            coef_reg.b2 <= '0;
            coef_reg.a1 <= '0;
            coef_reg.a2 <= '0;
        end else if (cfg_wr_en) begin
            // Unknown indexes fall through and are ignored.
            case (cfg_index)
                REG_ENABLE: enable_reg  <= cfg_wr_data[0];
                REG_B0:     coef_reg.b0 <= cfg_wr_data;
                REG_B1:     coef_reg.b1 <= cfg_wr_data;
                REG_B2:     coef_reg.b2 <= cfg_wr_data;
                REG_A1:     coef_reg.a1 <= cfg_wr_data;
                REG_A2:     coef_reg.a2 <= cfg_wr_data;
                default:    ;
            endcase
        end
    end

    // The output register is free when empty or being drained this cycle.
    assign out_free  = !m_valid_reg || m_ready;

    // A request is taken while idle, or in the cycle the previous result
    // moves into the output register, so back-to-back samples lose no cycle.
    assign s_ready   = seq.idle || seq.done;
    assign in_accept = s_valid && s_ready;

    biq_sequencer u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (in_accept),
        .filter_enable (enable_reg),
        .out_free      (out_free),
        .status        (seq)
    );

    biq_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .seq     (seq),
        .x_load  (in_accept),
        .x_in    (s_data.sample_in),
        .coefs   (coef_reg),
        .y_out   (y_value)
    );

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            block_end_reg <= s_data.block_end_in;
        end
        if (seq.done) begin
            out_reg.sample_out    <= y_value;
            out_reg.block_end_out <= block_end_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (seq.done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // The sequencer never finishes into an output register that still holds
    // an untaken result.
    a_done_into_free: assert property (@(posedge aclk) disable iff (!aresetn)
        seq.done |-> (!m_valid_reg || m_ready))
        else $error("result written over a pending output");

    // Every finished program run shows a result in the next cycle.
    a_done_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        seq.done |=> m_valid)
        else $error("finished run did not raise m_valid");

    // An accepted request starts the program from its first step.
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> (seq.run && seq.step == STEP_START))
        else $error("accepted request did not start the program");

    // With filtering off the delay states are never written.
    a_bypass_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (seq.fire && (seq.ctrl.d1_wr || seq.ctrl.d2_wr)) |-> enable_reg)
        else $error("delay state written while filtering is off");

endmodule

`default_nettype wire

// ----- bench/biquad_iir_filter_tb.sv -----
// ----------------------------------------------------------------------------
// biquad_iir_filter_tb
// Self-checking bench for the transposed direct form II biquad filter.
// A bit-exact fixed-point model predicts each filtered or passed-through
// sample as its request is accepted. Every delivered sample is compared
// with the oldest prediction. The run starts with directed cases: pass
// through, rounding ties, output saturation, extreme coefficients and state
// held while the filter is off. It then moves through many random
// coefficient settings, with random idling and stalls on both channels.
// ----------------------------------------------------------------------------

import biq_pkg::*;

class biquad_scoreboard;
    localparam int MAX_REPORTS = 20;

    bit                       filter_on;
    logic signed [COEF_W-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
    logic signed [ACC_W-1:0]  delay_first, delay_second;
    out_item_t                pending_samples[$];
    int unsigned              mismatches, checked, filtered, passed;

    function new();
        filter_on    = 1'b0;
        coef_b0      = COEF_W'(1) << COEF_FRAC;
        coef_b1      = '0;
        coef_b2      = '0;
        coef_a1      = '0;
        coef_a2      = '0;
        delay_first  = '0;
        delay_second = '0;
        mismatches   = 0;
        checked      = 0;
        filtered     = 0;
        passed       = 0;
    endfunction

    function longint saturate(longint v, int w);
        longint hi, lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
        case (idx)
            REG_ENABLE: filter_on = data[0];
            REG_B0:     coef_b0 = data;
            REG_B1:     coef_b1 = data;
            REG_B2:     coef_b2 = data;
            REG_A1:     coef_a1 = data;
            REG_A2:     coef_a2 = data;
            default: ;
        endcase
    endfunction

    // Runs one sample through the filter and queues the sample it must produce.
    function void note_request(in_item_t req);
        longint    x, y, sum;
        out_item_t r;
        x = longint'(req.sample_in);
        y = x;
        if (filter_on) begin
            sum = saturate(coef_b0 * x, ACC_W) + delay_first
                + (longint'(1) <<< (COEF_FRAC - 1));
            y = saturate(sum >>> COEF_FRAC, SAMPLE_W);
            // The second delay is read before it is overwritten.
            delay_first = ACC_W'(saturate(saturate(coef_b1 * x, ACC_W)
                                          - saturate(coef_a1 * y, ACC_W)
                                          + delay_second, ACC_W));
            delay_second = ACC_W'(saturate(saturate(coef_b2 * x, ACC_W)
                                           - saturate(coef_a2 * y, ACC_W), ACC_W));
            filtered++;
        end else begin
            passed++;
        end
        r.sample_out    = y[SAMPLE_W-1:0];
        r.block_end_out = req.block_end_in;
        pending_samples.push_back(r);
    endfunction

    function int pending();
        return pending_samples.size();
    endfunction

    task report_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at sample %0d: %s", checked, what);
    endtask

    task check_result(out_item_t got);
        out_item_t want;
        if (pending_samples.size() == 0) begin
            report_mismatch($sformatf("sample %0d delivered with no request waiting",
                                      got.sample_out));
            return;
        end
        want = pending_samples.pop_front();
        if (got.sample_out !== want.sample_out)
            report_mismatch($sformatf("sample_out %0d, predicted %0d",
                                      got.sample_out, want.sample_out));
        if (got.block_end_out !== want.block_end_out)
            report_mismatch($sformatf("block_end_out %0b, predicted %0b",
                                      got.block_end_out, want.block_end_out));
        checked++;
    endtask

    task report_leftovers();
        out_item_t want;
        while (pending_samples.size() != 0) begin
            want = pending_samples.pop_front();
            report_mismatch($sformatf("predicted sample %0d never delivered",
                                      want.sample_out));
        end
    endtask
endclass

module biquad_iir_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Run shape. Idling is a percentage per cycle at the sink and per request at the sender.
    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_ITEMS  = 1700;
    localparam int IDLE_PERCENT  = 26;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int CYCLE_LIMIT   = 400000;

    // Random settings that get special handling on either channel.
    localparam int CALM_PHASE  = 3;
    localparam int HOLD_PHASE  = 6;
    localparam int PAUSE_PHASE = 9;

    // Indexes past the last register; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] UNMAPPED_REG_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] UNMAPPED_REG_HI = 3'd7;

    localparam logic signed [COEF_W-1:0]   COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0]   COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic signed [COEF_W-1:0]   COEF_ONE   = COEF_W'(1) << COEF_FRAC;
    localparam logic signed [COEF_W-1:0]   COEF_HALF  = COEF_W'(1) << (COEF_FRAC - 1);
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // How random values are spread over their range.
    typedef enum int {
        SPREAD_FULL,
        SPREAD_QUIET,
        SPREAD_EDGES
    } spread_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    in_item_t              s_data      = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    out_item_t             m_data;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [COEF_W-1:0]     cfg_wr_data = '0;

    // Flags shared between the stimulus and the result sink, and run counters.
    bit                    calm_stretch = 1'b0;
    bit                    hold_sink    = 1'b0;
    int unsigned           cycle_count  = 0;
    int unsigned           settings_used = 0;

    biquad_scoreboard sb = new();

    biquad_iir_filter uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    // 8 ns clock, first rising edge at 4 ns.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // The watchdog bounds the whole run, including any drain that never ends.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("watchdog expired after %0d cycles", cycle_count);
            $display("biquad_iir_filter_tb: errors");
            $finish;
        end
    end

    // Both channels are observed at the clock edge, before any of this edge's
    // nonblocking updates land, so a request is noted before its sample can
    // come back. Requests are noted before results within one edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_request(s_data);
            if (m_valid && m_ready)
                sb.check_result(m_data);
        end
    end

    // Result sink. It normally drops ready at random. On request it holds ready
    // low for a counted stretch so that the filter fills up and stops taking
    // requests. During the calm stretch it never stalls.
    initial begin : result_sink
        int held;
        forever begin
            @(posedge aclk);
            if (hold_sink) begin
                m_ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge aclk);
                hold_sink = 1'b0;
            end else begin
                m_ready <= calm_stretch || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // One register write. The enable is dropped for a cycle before the next
    // write, so back-to-back calls never assign it twice in one step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        sb.set_register(idx, data);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Loads a full setting. The enable write carries random upper bits, which
    // only bit 0 of the register should see.
    task automatic program_filter(input bit en, input logic [COEF_W-1:0] b0,
                                  input logic [COEF_W-1:0] b1, input logic [COEF_W-1:0] b2,
                                  input logic [COEF_W-1:0] a1, input logic [COEF_W-1:0] a2);
        logic [COEF_W-1:0] en_word;
        en_word    = COEF_W'($urandom());
        en_word[0] = en;
        write_reg(REG_ENABLE, en_word);
        write_reg(REG_B0, b0);
        write_reg(REG_B1, b1);
        write_reg(REG_B2, b2);
        write_reg(REG_A1, a1);
        write_reg(REG_A2, a2);
        settings_used++;
    endtask

    // Offers one sample request and returns at the edge where it is taken.
    // Valid is not lowered between back-to-back requests unless a gap is drawn.
    task automatic send_request(input logic [SAMPLE_W-1:0] sample, input logic block_end);
        in_item_t req;
        int       gap;
        req.sample_in    = sample;
        req.block_end_in = block_end;
        if (!calm_stretch && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 9);
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // Stops offering and waits until every predicted sample has come back, then
    // lets the filter settle so that a register write finds it idle.
    task automatic wait_drained();
        int waited;
        s_valid <= 1'b0;
        @(posedge aclk);
        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [SAMPLE_W-1:0] random_sample(input spread_t spread);
        case (spread)
            SPREAD_QUIET: return SAMPLE_W'($urandom_range(0, 4095) - 2048);
            SPREAD_EDGES: begin
                case ($urandom_range(3))
                    0:       return SAMPLE_MAX;
                    1:       return SAMPLE_MIN;
                    2:       return '0;
                    default: return SAMPLE_W'($urandom());
                endcase
            end
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // Quiet coefficients stay within plus or minus 1.0, which gives filters
    // that mostly ring down instead of running into the rails.
    function automatic logic [COEF_W-1:0] random_coef(input spread_t spread);
        case (spread)
            SPREAD_QUIET: return COEF_W'($urandom_range(0, 2 * COEF_ONE) - COEF_ONE);
            SPREAD_EDGES: begin
                case ($urandom_range(3))
                    0:       return COEF_MAX;
                    1:       return COEF_MIN;
                    2:       return '0;
                    default: return COEF_W'($urandom());
                endcase
            end
            default: return COEF_W'($urandom());
        endcase
    endfunction

    initial begin : stimulus
        int      phase;
        int      count;
        int      i;
        int      random_sent;
        bit      en;
        spread_t coef_spread;
        spread_t sample_spread;

        // Reset is held from time zero for a fixed number of cycles.
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Out of reset the filter is off. Writes to the unmapped indexes must
        // be ignored, and samples must pass through with their flags.
        write_reg(UNMAPPED_REG_LO, COEF_W'($urandom()));
        write_reg(UNMAPPED_REG_HI, COEF_W'($urandom()));
        send_request(SAMPLE_MIN, 1'b1);
        send_request(SAMPLE_MAX, 1'b0);
        send_request(SAMPLE_W'(0), 1'b0);
        send_request(SAMPLE_W'(-1), 1'b1);
        wait_drained();

        // Turning the filter on with the reset coefficients (b0 = 1.0 and all
        // others zero) must give an identity filter.
        write_reg(REG_ENABLE, COEF_W'(1));
        send_request(SAMPLE_MAX, 1'b0);
        send_request(SAMPLE_MIN, 1'b1);
        send_request(SAMPLE_W'(12345), 1'b0);
        wait_drained();

        // With b0 = 0.5, odd samples land exactly on a rounding tie. Ties
        // round upward, so -0.5 goes to zero and 1.5 goes to 2.
        program_filter(1'b1, COEF_HALF, '0, '0, '0, '0);
        send_request(SAMPLE_W'(1), 1'b0);
        send_request(SAMPLE_W'(-1), 1'b0);
        send_request(SAMPLE_W'(3), 1'b1);
        send_request(SAMPLE_W'(-3), 1'b0);
        wait_drained();

        // Extreme coefficients with full-scale input drive the output into
        // both rails and put the largest terms into the feedback.
        program_filter(1'b1, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX);
        send_request(SAMPLE_MAX, 1'b0);
        send_request(SAMPLE_MIN, 1'b0);
        send_request(SAMPLE_MAX, 1'b1);
        send_request(SAMPLE_MIN, 1'b0);
        send_request(SAMPLE_W'(0), 1'b0);
        wait_drained();
        program_filter(1'b1, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX, COEF_MIN);
        send_request(SAMPLE_MIN, 1'b0);
        send_request(SAMPLE_MAX, 1'b1);
        send_request(SAMPLE_W'(0), 1'b0);
        send_request(SAMPLE_W'(0), 1'b0);
        wait_drained();

        // The delay state is left nonzero here. While the filter is off it must
        // be held, so the zero samples after re-enabling still show its tail.
        write_reg(REG_ENABLE, COEF_W'(0));
        send_request(SAMPLE_W'(100), 1'b0);
        send_request(SAMPLE_W'(-100), 1'b1);
        wait_drained();
        write_reg(REG_ENABLE, COEF_W'(1));
        send_request(SAMPLE_W'(0), 1'b0);
        send_request(SAMPLE_W'(0), 1'b0);
        wait_drained();

        // Random settings, each followed by a burst of random samples. Most
        // settings have the filter on. One setting runs with no idling at all,
        // one holds the sink off, and one pauses the sender halfway until the
        // filter has delivered everything.
        random_sent = 0;
        phase       = 0;
        while (random_sent < RANDOM_ITEMS) begin
            phase++;
            en            = ($urandom_range(4) != 0);
            coef_spread   = spread_t'($urandom_range(2));
            sample_spread = ($urandom_range(2) == 0) ? spread_t'($urandom_range(2))
                                                     : SPREAD_FULL;
            program_filter(en, random_coef(coef_spread), random_coef(coef_spread),
                           random_coef(coef_spread), random_coef(coef_spread),
                           random_coef(coef_spread));
            if ($urandom_range(3) == 0)
                write_reg($urandom_range(1) ? UNMAPPED_REG_LO : UNMAPPED_REG_HI,
                          COEF_W'($urandom()));

            calm_stretch = (phase == CALM_PHASE);
            if (phase == HOLD_PHASE)
                hold_sink = 1'b1;

            count = $urandom_range(60, 140);
            for (i = 0; i < count; i++) begin
                if (phase == PAUSE_PHASE && i == count / 2)
                    wait_drained();
                send_request(random_sample(sample_spread), $urandom_range(7) == 0);
            end
            random_sent += count;
            wait_drained();
            calm_stretch = 1'b0;
        end

        // Anything still predicted at this point was lost by the filter.
        sb.report_leftovers();

        $display("Checked %0d samples: %0d filtered, %0d passed through, over %0d settings.",
                 sb.checked, sb.filtered, sb.passed, settings_used);
        $display("Covered ties, both rails, extreme coefficients, a sink stall; %0d mismatches.",
                 sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("biquad_iir_filter_tb: clean");
        end else begin
            $display("biquad_iir_filter_tb: errors");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/biq_pkg.sv
sv/biq_sequencer.sv
sv/biq_datapath.sv
sv/biquad_iir_filter.sv
bench/biquad_iir_filter_tb.sv
